// ===== src/ptfk_pkg.sv =====
package ptfk_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int NUM_LANES    = 10;
    localparam int NUM_PARAMS   = 18;
    localparam int ROT_W        = 30;
    localparam int TRANS_W      = 32;
    localparam int OUT_W        = 208;

    // sin/cos lanes of the trig pipeline
    localparam int LANE_PAN  = 0;
    localparam int LANE_TILT = 1;
    localparam int LANE_P1X  = 2;
    localparam int LANE_P1Y  = 3;
    localparam int LANE_P1Z  = 4;
    localparam int LANE_A1   = 5;
    localparam int LANE_A2   = 6;
    localparam int LANE_P2X  = 7;
    localparam int LANE_P2Y  = 8;
    localparam int LANE_P2Z  = 9;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] PI_Q28          = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28     = 32'sd421657428;

    localparam logic signed [31:0] ATAN_Q28 [CORDIC_STEPS] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WORD_0 = 3'd1,
        REG_WORD_1 = 3'd2,
        REG_WORD_2 = 3'd3,
        REG_WORD_3 = 3'd4,
        REG_WORD_4 = 3'd5
    } cfg_index_t;

    typedef logic signed [15:0]              angle_t;
    typedef logic signed [15:0]              param_t;
    typedef logic signed [ROT_W-1:0]         rot_t;
    typedef logic signed [TRANS_W-1:0]       trans_t;
    typedef logic signed [ROT_W+TRANS_W-1:0] prod_t;

    localparam rot_t ONE_Q28 = rot_t'(268435456);

    typedef struct packed {
        rot_t   [2:0][2:0] r;
        trans_t [2:0]      t;
    } xform_t;

    typedef struct packed {
        xform_t m0;
        xform_t m1;
    } xform_pair_t;

    typedef struct packed {
        xform_t p1;
        xform_t l1;
        xform_t l2;
        xform_t p2;
    } frames_t;

    typedef struct packed {
        rot_t [NUM_LANES-1:0] sin_v;
        rot_t [NUM_LANES-1:0] cos_v;
    } sincos_t;

    // q.28 product, rounded half up
    function automatic rot_t mq(input rot_t a, input rot_t b);
        logic signed [2*ROT_W-1:0] p;
        p = a * b;
        p = p + {{(2*ROT_W-28){1'b0}}, 1'b1, 27'b0};
        return p[ROT_W+27:28];
    endfunction

    function automatic prod_t prod_rr(input rot_t a, input rot_t b);
        prod_t pa;
        prod_t pb;
        pa = prod_t'(a);
        pb = prod_t'(b);
        return pa * pb;
    endfunction

    function automatic prod_t prod_rt(input rot_t a, input trans_t b);
        prod_t pa;
        prod_t pb;
        pa = prod_t'(a);
        pb = prod_t'(b);
        return pa * pb;
    endfunction

endpackage

// ===== src/ptfk_sincos.sv =====
module ptfk_sincos (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  ptfk_pkg::angle_t [ptfk_pkg::NUM_LANES-1:0] angle,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output ptfk_pkg::sincos_t                       sc
);
    import ptfk_pkg::*;

    localparam int LAST = CORDIC_STEPS + 1;

    typedef logic signed [32:0] vec_t;
    typedef logic signed [31:0] zang_t;

    logic [LAST:0] vld_reg;
    logic [LAST:0] en;

    vec_t                 x_reg     [0:CORDIC_STEPS][NUM_LANES];
    vec_t                 y_reg     [0:CORDIC_STEPS][NUM_LANES];
    zang_t                z_reg     [0:CORDIC_STEPS][NUM_LANES];
    logic [NUM_LANES-1:0] flip_reg  [0:CORDIC_STEPS];
    vec_t                 x_next    [0:CORDIC_STEPS][NUM_LANES];
    vec_t                 y_next    [0:CORDIC_STEPS][NUM_LANES];
    zang_t                z_next    [0:CORDIC_STEPS][NUM_LANES];
    logic [NUM_LANES-1:0] flip_next [0:CORDIC_STEPS];
    rot_t                 sin_reg   [NUM_LANES];
    rot_t                 cos_reg   [NUM_LANES];
    rot_t                 sin_next  [NUM_LANES];
    rot_t                 cos_next  [NUM_LANES];

    always_comb begin
        en[LAST] = !vld_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[LAST];

    // range reduction to +-pi/2, then one micro-rotation per stage
    always_comb begin
        zang_t zin;
        vec_t  cr;
        vec_t  sr;
        for (int l = 0; l < NUM_LANES; l++) begin
            zin = {angle[l][15], angle[l], 15'b0};
            x_next[0][l]    = vec_t'(CORDIC_GAIN_Q30);
            y_next[0][l]    = '0;
            flip_next[0][l] = 1'b0;
            z_next[0][l]    = zin;
            if (zin > HALF_PI_Q28) begin
                z_next[0][l]    = zin - PI_Q28;
                flip_next[0][l] = 1'b1;
            end else if (zin < -HALF_PI_Q28) begin
                z_next[0][l]    = zin + PI_Q28;
                flip_next[0][l] = 1'b1;
            end
        end
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            flip_next[k] = flip_reg[k-1];
            for (int l = 0; l < NUM_LANES; l++) begin
                if (z_reg[k-1][l] >= 0) begin
                    x_next[k][l] = x_reg[k-1][l] - (y_reg[k-1][l] >>> (k - 1));
                    y_next[k][l] = y_reg[k-1][l] + (x_reg[k-1][l] >>> (k - 1));
                    z_next[k][l] = z_reg[k-1][l] - ATAN_Q28[k-1];
                end else begin
                    x_next[k][l] = x_reg[k-1][l] + (y_reg[k-1][l] >>> (k - 1));
                    y_next[k][l] = y_reg[k-1][l] - (x_reg[k-1][l] >>> (k - 1));
                    z_next[k][l] = z_reg[k-1][l] + ATAN_Q28[k-1];
                end
            end
        end
        // q.30 to q.28, undo the half-turn fold
        for (int l = 0; l < NUM_LANES; l++) begin
            cr = (x_reg[CORDIC_STEPS][l] + vec_t'(2)) >>> 2;
            sr = (y_reg[CORDIC_STEPS][l] + vec_t'(2)) >>> 2;
            cos_next[l] = cr[ROT_W-1:0];
            sin_next[l] = sr[ROT_W-1:0];
            if (flip_reg[CORDIC_STEPS][l]) begin
                cos_next[l] = -cr[ROT_W-1:0];
                sin_next[l] = -sr[ROT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k <= CORDIC_STEPS; k++) begin
            if (en[k]) begin
                flip_reg[k] <= flip_next[k];
                for (int l = 0; l < NUM_LANES; l++) begin
                    x_reg[k][l] <= x_next[k][l];
                    y_reg[k][l] <= y_next[k][l];
                    z_reg[k][l] <= z_next[k][l];
                end
            end
        end
        if (en[LAST]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                sin_reg[l] <= sin_next[l];
                cos_reg[l] <= cos_next[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            sc.sin_v[l] = sin_reg[l];
            sc.cos_v[l] = cos_reg[l];
        end
    end

endmodule

// ===== src/ptfk_frames.sv =====
module ptfk_frames (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  ptfk_pkg::sincos_t                          sc,
    input  logic                                       mode,
    input  ptfk_pkg::param_t [ptfk_pkg::NUM_PARAMS-1:0] prm,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output ptfk_pkg::frames_t                          frames
);
    import ptfk_pkg::*;

    typedef struct packed {
        rot_t sxsy;
        rot_t cxsy;
        rot_t r00;
        rot_t r01;
        rot_t r02;
        rot_t r12;
        rot_t r22;
        rot_t cx_sz;
        rot_t cx_cz;
        rot_t sx_sz;
        rot_t sx_cz;
        rot_t sz;
        rot_t cz;
    } pose_mid_t;

    function automatic pose_mid_t pose_first(input rot_t sx, input rot_t cx, input rot_t sy,
                                             input rot_t cy, input rot_t sz, input rot_t cz);
        pose_mid_t m;
        m.sxsy  = mq(sx, sy);
        m.cxsy  = mq(cx, sy);
        m.r00   = mq(cy, cz);
        m.r01   = -mq(cy, sz);
        m.r02   = sy;
        m.r12   = -mq(sx, cy);
        m.r22   = mq(cx, cy);
        m.cx_sz = mq(cx, sz);
        m.cx_cz = mq(cx, cz);
        m.sx_sz = mq(sx, sz);
        m.sx_cz = mq(sx, cz);
        m.sz    = sz;
        m.cz    = cz;
        return m;
    endfunction

    function automatic trans_t len_to_trans(input param_t v);
        return trans_t'($signed({v, 12'b0}));
    endfunction

    function automatic xform_t pose_second(input pose_mid_t m, input param_t tx,
                                           input param_t ty, input param_t tz);
        xform_t x;
        x.r[0][0] = m.r00;
        x.r[0][1] = m.r01;
        x.r[0][2] = m.r02;
        x.r[1][0] = mq(m.sxsy, m.cz) + m.cx_sz;
        x.r[1][1] = m.cx_cz - mq(m.sxsy, m.sz);
        x.r[1][2] = m.r12;
        x.r[2][0] = m.sx_sz - mq(m.cxsy, m.cz);
        x.r[2][1] = mq(m.cxsy, m.sz) + m.sx_cz;
        x.r[2][2] = m.r22;
        x.t[0]    = len_to_trans(tx);
        x.t[1]    = len_to_trans(ty);
        x.t[2]    = len_to_trans(tz);
        return x;
    endfunction

    function automatic trans_t scale_len(input param_t r, input rot_t c);
        logic signed [ROT_W+15:0] p;
        p = r * c;
        p = p + {{ROT_W{1'b0}}, 1'b1, 15'b0};
        return trans_t'($signed(p[ROT_W+15:16]));
    endfunction

    function automatic xform_t make_link(input rot_t st, input rot_t ct, input rot_t sa,
                                         input rot_t ca, input param_t d, input param_t r);
        xform_t x;
        x.r[0][0] = ct;
        x.r[0][1] = -mq(st, ca);
        x.r[0][2] = mq(st, sa);
        x.r[1][0] = st;
        x.r[1][1] = mq(ct, ca);
        x.r[1][2] = -mq(ct, sa);
        x.r[2][0] = '0;
        x.r[2][1] = sa;
        x.r[2][2] = ca;
        x.t[0]    = scale_len(r, ct);
        x.t[1]    = scale_len(r, st);
        x.t[2]    = len_to_trans(d);
        return x;
    endfunction

    logic [1:0] vld_reg;
    logic [1:0] en;

    pose_mid_t mid1_reg, mid2_reg, mid1_next, mid2_next;
    xform_t    link1_reg, link2_reg, link1_next, link2_next;
    frames_t   frames_reg, frames_next;

    rot_t   sa1, ca1, sa2, ca2;
    param_t d1, r1, d2, r2;

    always_comb begin
        en[1] = !vld_reg[1] || out_ready;
        en[0] = !vld_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[1];
    assign frames    = frames_reg;

    // stage 1: first pose products and both links
    always_comb begin
        if (mode) begin
            sa1 = ONE_Q28;
            ca1 = '0;
            sa2 = ONE_Q28;
            ca2 = '0;
            d1  = '0;
            r1  = '0;
            d2  = prm[6];
            r2  = prm[7];
        end else begin
            sa1 = sc.sin_v[LANE_A1];
            ca1 = sc.cos_v[LANE_A1];
            sa2 = sc.sin_v[LANE_A2];
            ca2 = sc.cos_v[LANE_A2];
            d1  = prm[6];
            r1  = prm[7];
            d2  = prm[9];
            r2  = prm[10];
        end
        mid1_next = pose_first(sc.sin_v[LANE_P1X], sc.cos_v[LANE_P1X],
                               sc.sin_v[LANE_P1Y], sc.cos_v[LANE_P1Y],
                               sc.sin_v[LANE_P1Z], sc.cos_v[LANE_P1Z]);
        mid2_next = pose_first(sc.sin_v[LANE_P2X], sc.cos_v[LANE_P2X],
                               sc.sin_v[LANE_P2Y], sc.cos_v[LANE_P2Y],
                               sc.sin_v[LANE_P2Z], sc.cos_v[LANE_P2Z]);
        link1_next = make_link(sc.sin_v[LANE_PAN], sc.cos_v[LANE_PAN], sa1, ca1, d1, r1);
        link2_next = make_link(sc.sin_v[LANE_TILT], sc.cos_v[LANE_TILT], sa2, ca2, d2, r2);
    end

    // stage 2: finish the poses
    always_comb begin
        frames_next.p1 = pose_second(mid1_reg, prm[3], prm[4], prm[5]);
        frames_next.l1 = link1_reg;
        frames_next.l2 = link2_reg;
        if (mode) begin
            frames_next.p2 = pose_second(mid2_reg, '0, '0, prm[11]);
        end else begin
            frames_next.p2 = pose_second(mid2_reg, prm[15], prm[16], prm[17]);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            if (en[1]) begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            mid1_reg  <= mid1_next;
            mid2_reg  <= mid2_next;
            link1_reg <= link1_next;
            link2_reg <= link2_next;
        end
        if (en[1]) begin
            frames_reg <= frames_next;
        end
    end

endmodule

// ===== src/ptfk_compose.sv =====
module ptfk_compose (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ptfk_pkg::xform_t      a,
    input  ptfk_pkg::xform_t      b,
    input  ptfk_pkg::xform_pair_t side_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ptfk_pkg::xform_t      o,
    output ptfk_pkg::xform_pair_t side_out
);
    import ptfk_pkg::*;

    typedef logic signed [ROT_W+TRANS_W+1:0] sum_t;

    localparam sum_t HALF_Q28 = sum_t'(1) <<< 27;

    logic [1:0] vld_reg;
    logic [1:0] en;

    prod_t       r_prod_reg  [3][3][3];
    prod_t       r_prod_next [3][3][3];
    prod_t       t_prod_reg  [3][3];
    prod_t       t_prod_next [3][3];
    trans_t      at_reg      [3];
    xform_pair_t side_a_reg;
    xform_pair_t side_b_reg;
    xform_t      o_reg, o_next;

    always_comb begin
        en[1] = !vld_reg[1] || out_ready;
        en[0] = !vld_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[1];
    assign o         = o_reg;
    assign side_out  = side_b_reg;

    // stage a: all products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod_next[i][j][k] = prod_rr(a.r[i][k], b.r[k][j]);
                end
                t_prod_next[i][k] = prod_rt(a.r[i][k], b.t[k]);
            end
        end
    end

    // stage b: exact three-term sums, one rounding each
    always_comb begin
        sum_t s;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = sum_t'(r_prod_reg[i][j][0]) + sum_t'(r_prod_reg[i][j][1])
                    + sum_t'(r_prod_reg[i][j][2]) + HALF_Q28;
                o_next.r[i][j] = s[ROT_W+27:28];
            end
            s = sum_t'(t_prod_reg[i][0]) + sum_t'(t_prod_reg[i][1])
                + sum_t'(t_prod_reg[i][2]) + HALF_Q28;
            o_next.t[i] = $signed(s[TRANS_W+27:28]) + at_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            if (en[1]) begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            r_prod_reg <= r_prod_next;
            t_prod_reg <= t_prod_next;
            side_a_reg <= side_in;
            for (int i = 0; i < 3; i++) begin
                at_reg[i] <= a.t[i];
            end
        end
        if (en[1]) begin
            o_reg      <= o_next;
            side_b_reg <= side_a_reg;
        end
    end

endmodule

// ===== src/ptfk_output.sv =====
module ptfk_output (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ptfk_pkg::xform_t           acc,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ptfk_pkg::OUT_W-1:0] out_data
);
    import ptfk_pkg::*;

    typedef logic signed [ROT_W-15:0]  rsh_t;
    typedef logic signed [TRANS_W-12:0] tsh_t;

    localparam rsh_t ROT_MAX   = rsh_t'(16384);
    localparam rsh_t ROT_MIN   = rsh_t'(-16384);
    localparam tsh_t TRANS_MAX = tsh_t'(524287);
    localparam tsh_t TRANS_MIN = tsh_t'(-524288);

    logic             vld_reg;
    logic             en;
    logic [OUT_W-1:0] data_reg, data_next;

    assign en        = !vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // round to output scale and clamp
    always_comb begin
        rot_t                   rv;
        rsh_t                   rs;
        logic signed [TRANS_W:0] tv;
        tsh_t                   ts;
        data_next = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rv = acc.r[i][j];
                rv = rv + rot_t'(8192);
                rs = $signed(rv[ROT_W-1:14]);
                if (rs > ROT_MAX) begin
                    rs = ROT_MAX;
                end else if (rs < ROT_MIN) begin
                    rs = ROT_MIN;
                end
                data_next[16*(3*i+j) +: 16] = rs[15:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            tv = (TRANS_W+1)'(acc.t[i]);
            tv = tv + (TRANS_W+1)'(2048);
            ts = $signed(tv[TRANS_W:12]);
            if (ts > TRANS_MAX) begin
                ts = TRANS_MAX;
            end else if (ts < TRANS_MIN) begin
                ts = TRANS_MIN;
            end
            data_next[144+20*i +: 20] = ts[19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/pan_tilt_forward_kinematics_unit.sv =====
// pan/tilt forward kinematics: each transaction on the slave stream carries a pan and a
// tilt angle and yields one transaction on the master stream with the rigid transform
// from camera one to camera two (fixed pose, pan link, tilt link, fixed pose). the
// datapath is a 35-stage pipeline: 26 stages of pipelined cordic (ten sin/cos lanes,
// one per joint and calibration angle), 2 stages that build the four frames, 2 stages
// for each of the three 3x4 matrix products and 1 output stage for rounding and
// clamping. one transaction is taken per clock while the output is not stalled; every
// stage holds its item only while the stage after it is full, so back-pressure fills
// bubbles before it reaches the input. calibration registers feed the pipeline directly
// and must only be written while no transaction is in flight; a transaction may follow a
// write in the next cycle.
module pan_tilt_forward_kinematics_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // pan_angle, tilt_angle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [207:0] m_axis_tdata,   // rot_00..rot_22, trans_x, trans_y, trans_z, 4'b0
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import ptfk_pkg::*;

    // calibration registers
    logic        mode_reg;
    logic [63:0] word_reg [4];
    logic [31:0] word4_reg;

    logic [63:0]                words [5];
    param_t [NUM_PARAMS-1:0]    prm;
    angle_t [NUM_LANES-1:0]     angle;

    // stage handshakes between units
    logic        sc_valid, sc_ready;
    sincos_t     sc;
    logic        fr_valid, fr_ready;
    frames_t     frames;
    logic        c1_valid, c1_ready;
    xform_t      c1_o;
    xform_pair_t c1_side;
    logic        c2_valid, c2_ready;
    xform_t      c2_o;
    xform_pair_t c2_side;
    logic        c3_valid, c3_ready;
    xform_t      c3_o;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= 1'b0;
            word_reg  <= '{default: '0};
            word4_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:   mode_reg    <= cfg_data[0];
                REG_WORD_0: word_reg[0] <= cfg_data;
                REG_WORD_1: word_reg[1] <= cfg_data;
                REG_WORD_2: word_reg[2] <= cfg_data;
                REG_WORD_3: word_reg[3] <= cfg_data;
                REG_WORD_4: word4_reg   <= cfg_data[31:0];
                default:    ;   // writes past the last register are dropped
            endcase
        end
    end

    // calibration parameter k is the k%4-th 16-bit field of word k/4
    always_comb begin
        for (int w = 0; w < 4; w++) begin
            words[w] = word_reg[w];
        end
        words[4] = {32'b0, word4_reg};
        for (int k = 0; k < NUM_PARAMS; k++) begin
            prm[k] = words[k/4][16*(k%4) +: 16];
        end
    end

    // angle lanes; the second pose draws on different fields in the short chain
    always_comb begin
        angle[LANE_PAN]  = s_axis_tdata[15:0];
        angle[LANE_TILT] = s_axis_tdata[31:16];
        angle[LANE_P1X]  = prm[0];
        angle[LANE_P1Y]  = prm[1];
        angle[LANE_P1Z]  = prm[2];
        angle[LANE_A1]   = prm[8];
        angle[LANE_A2]   = prm[11];
        if (mode_reg) begin
            angle[LANE_P2X] = prm[8];
            angle[LANE_P2Y] = prm[9];
            angle[LANE_P2Z] = prm[10];
        end else begin
            angle[LANE_P2X] = prm[12];
            angle[LANE_P2Y] = prm[13];
            angle[LANE_P2Z] = prm[14];
        end
    end

    ptfk_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .angle     (angle),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .sc        (sc)
    );

    ptfk_frames u_frames (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .sc        (sc),
        .mode      (mode_reg),
        .prm       (prm),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .frames    (frames)
    );

    // first pose times pan link; tilt link and second pose ride along
    ptfk_compose u_compose_pan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .a         (frames.p1),
        .b         (frames.l1),
        .side_in   ('{m0: frames.l2, m1: frames.p2}),
        .out_valid (c1_valid),
        .out_ready (c1_ready),
        .o         (c1_o),
        .side_out  (c1_side)
    );

    ptfk_compose u_compose_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_ready  (c1_ready),
        .a         (c1_o),
        .b         (c1_side.m0),
        .side_in   ('{m0: c1_side.m1, m1: c1_side.m1}),
        .out_valid (c2_valid),
        .out_ready (c2_ready),
        .o         (c2_o),
        .side_out  (c2_side)
    );

    ptfk_compose u_compose_pose (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c2_valid),
        .in_ready  (c2_ready),
        .a         (c2_o),
        .b         (c2_side.m0),
        .side_in   (c2_side),
        .out_valid (c3_valid),
        .out_ready (c3_ready),
        .o         (c3_o),
        .side_out  ()
    );

    ptfk_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c3_valid),
        .in_ready  (c3_ready),
        .acc       (c3_o),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== tb/tb_pan_tilt_forward_kinematics_unit.sv =====
module tb_pan_tilt_forward_kinematics_unit;
    import ptfk_pkg::*;

    localparam int RAND_ITEMS = 1000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;     // a bit over the 35-stage pipeline

    // one rigid transform: rotation in q.28, translation in 2^-24 m
    typedef struct {
        longint r[3][3];
        longint t[3];
    } frame_t;

    // one output transaction, fields as they sit in m_axis_tdata
    typedef struct packed {
        logic [2:0][19:0] trans;
        logic [8:0][15:0] rot;
    } pose_out_t;

    // one row of the directed table; zero_trans marks rows whose translation
    // must read zero because every length register is still at reset
    typedef struct packed {
        logic [15:0] pan;
        logic [15:0] tilt;
        logic        zero_trans;
    } stim_row_t;

    localparam longint PI_FX   = 64'sd843314857;
    localparam longint HPI_FX  = 64'sd421657428;
    localparam longint GAIN_FX = 64'sd652032874;
    localparam longint UNIT_FX = 64'sd268435456;

    localparam longint ARCTAN [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    // extremes of both angles, pi/2 boundary, the wrap beyond +-pi, small values
    localparam int NUM_ROWS = 14;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{16'h0000, 16'h0000, 1'b1},
        '{16'h6488, 16'h9b78, 1'b1},   // +25736 / -25736
        '{16'h9b78, 16'h6488, 1'b1},
        '{16'h7fff, 16'h8000, 1'b1},   // full 16-bit extremes, beyond pi
        '{16'h8000, 16'h7fff, 1'b1},
        '{16'h3244, 16'hcdbc, 1'b1},   // right at +-pi/2
        '{16'h3245, 16'hcdbb, 1'b1},   // just past +-pi/2
        '{16'h0001, 16'hffff, 1'b1},
        '{16'h5555, 16'haaaa, 1'b1},
        '{16'haaaa, 16'h5555, 1'b1},
        '{16'h1922, 16'h1922, 1'b1},   // pi/4
        '{16'h6487, 16'h6489, 1'b1},   // around pi
        '{16'hffff, 16'h0001, 1'b1},
        '{16'h4000, 16'hc000, 1'b1}
    };

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;    // pan_angle, tilt_angle
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;    // rot_00..rot_22, trans_x, trans_y, trans_z, pad
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    // shadow of the calibration registers
    logic         chain_mode;
    logic [63:0]  calib_words [5];

    pose_out_t    pending_poses [$];
    bit           zero_trans_q [$];
    int           error_count;
    int           cycle_count;
    int           burst_left;
    int           stall_kind;

    pan_tilt_forward_kinematics_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // rounding shift, half toward plus infinity
    function automatic longint round_sh(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return round_sh(a * b, 28);
    endfunction

    function automatic longint calib_param(input int k);
        logic [15:0] f;
        f = calib_words[k / 4] >> (16 * (k % 4));
        return longint'($signed(f));
    endfunction

    // q3.13 angle to q.28 sine and cosine through a 24-step cordic
    function automatic void angle_sincos(input longint ang, output longint s,
                                         output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = ang * 32768;
        x = GAIN_FX;
        y = 0;
        flip = 1'b0;
        if (z > HPI_FX)
        begin
            z -= PI_FX;
            flip = 1'b1;
        end
        else if (z < -HPI_FX)
        begin
            z += PI_FX;
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ARCTAN[i];
            end
            x = nx;
        end
        c = round_sh(x, 2);
        s = round_sh(y, 2);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    // xyz euler pose
    function automatic void euler_pose(output frame_t m, input longint rx, input longint ry,
                                       input longint rz, input longint tx, input longint ty,
                                       input longint tz);
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        angle_sincos(rx, sx, cx);
        angle_sincos(ry, sy, cy);
        angle_sincos(rz, sz, cz);
        sxsy = fx_mul(sx, sy);
        cxsy = fx_mul(cx, sy);
        m.r[0][0] = fx_mul(cy, cz);
        m.r[0][1] = -fx_mul(cy, sz);
        m.r[0][2] = sy;
        m.r[1][0] = fx_mul(sxsy, cz) + fx_mul(cx, sz);
        m.r[1][1] = -fx_mul(sxsy, sz) + fx_mul(cx, cz);
        m.r[1][2] = -fx_mul(sx, cy);
        m.r[2][0] = -fx_mul(cxsy, cz) + fx_mul(sx, sz);
        m.r[2][1] = fx_mul(cxsy, sz) + fx_mul(sx, cz);
        m.r[2][2] = fx_mul(cx, cy);
        m.t[0] = tx * 4096;
        m.t[1] = ty * 4096;
        m.t[2] = tz * 4096;
    endfunction

    // denavit-hartenberg link with twist given as sine and cosine
    function automatic void dh_link(output frame_t m, input longint theta, input longint d,
                                    input longint len, input longint sa, input longint ca);
        longint st, ct;
        angle_sincos(theta, st, ct);
        m.r[0][0] = ct;
        m.r[0][1] = -fx_mul(st, ca);
        m.r[0][2] = fx_mul(st, sa);
        m.r[1][0] = st;
        m.r[1][1] = fx_mul(ct, ca);
        m.r[1][2] = -fx_mul(ct, sa);
        m.r[2][0] = 0;
        m.r[2][1] = sa;
        m.r[2][2] = ca;
        m.t[0] = round_sh(len * ct, 16);
        m.t[1] = round_sh(len * st, 16);
        m.t[2] = d * 4096;
    endfunction

    function automatic void chain(output frame_t o, input frame_t a, input frame_t b);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                o.r[i][j] = round_sh(a.r[i][0] * b.r[0][j] + a.r[i][1] * b.r[1][j]
                                     + a.r[i][2] * b.r[2][j], 28);
            o.t[i] = round_sh(a.r[i][0] * b.t[0] + a.r[i][1] * b.t[1]
                              + a.r[i][2] * b.t[2], 28) + a.t[i];
        end
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // camera-to-camera transform for one angle pair under the current calibration
    function automatic pose_out_t camera_pose(input logic [15:0] pan, input logic [15:0] tilt);
        frame_t    p1, l1, l2, p2, acc, tmp;
        longint    sa, ca;
        pose_out_t res;
        euler_pose(p1, calib_param(0), calib_param(1), calib_param(2),
                   calib_param(3), calib_param(4), calib_param(5));
        if (chain_mode == 1'b0)
        begin
            angle_sincos(calib_param(8), sa, ca);
            dh_link(l1, longint'($signed(pan)), calib_param(6), calib_param(7), sa, ca);
            angle_sincos(calib_param(11), sa, ca);
            dh_link(l2, longint'($signed(tilt)), calib_param(9), calib_param(10), sa, ca);
            euler_pose(p2, calib_param(12), calib_param(13), calib_param(14),
                       calib_param(15), calib_param(16), calib_param(17));
        end
        else
        begin
            // both twists fixed at pi/2
            dh_link(l1, longint'($signed(pan)), 0, 0, UNIT_FX, 0);
            dh_link(l2, longint'($signed(tilt)), calib_param(6), calib_param(7), UNIT_FX, 0);
            euler_pose(p2, calib_param(8), calib_param(9), calib_param(10),
                       0, 0, calib_param(11));
        end
        chain(acc, p1, l1);
        chain(tmp, acc, l2);
        chain(acc, tmp, p2);
        for (int i = 0; i < 9; i++)
            res.rot[i] = 16'(clamp(round_sh(acc.r[i / 3][i % 3], 14), -16384, 16384));
        for (int i = 0; i < 3; i++)
            res.trans[i] = 20'(clamp(round_sh(acc.t[i], 12), -524288, 524287));
        return res;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:   chain_mode = value[0];
            REG_WORD_0: calib_words[0] = value;
            REG_WORD_1: calib_words[1] = value;
            REG_WORD_2: calib_words[2] = value;
            REG_WORD_3: calib_words[3] = value;
            REG_WORD_4: calib_words[4] = {32'b0, value[31:0]};
            default: ;  // indexes past the list are ignored
        endcase
    endtask

    // wait for the pipeline to empty out before touching calibration
    task automatic drain_pipeline;
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_calibration(input logic [63:0] mode_val, input logic [63:0] w0,
                                    input logic [63:0] w1, input logic [63:0] w2,
                                    input logic [63:0] w3, input logic [63:0] w4);
        drain_pipeline();
        write_reg(REG_MODE, mode_val);
        write_reg(REG_WORD_0, w0);
        write_reg(REG_WORD_1, w1);
        write_reg(REG_WORD_2, w2);
        write_reg(REG_WORD_3, w3);
        write_reg(REG_WORD_4, w4);
    endtask

    // drive one transaction; the sender runs in bursts with random gaps between
    task automatic send_angles(input logic [15:0] pan, input logic [15:0] tilt,
                               input bit zero_trans);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tilt, pan};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_poses.push_back(camera_pose(pan, tilt));
        zero_trans_q.push_back(zero_trans);
        burst_left--;
    endtask

    // the zero translation check only holds while calibration is at reset
    task automatic run_directed(input bit at_reset);
        for (int i = 0; i < NUM_ROWS; i++)
            send_angles(DIRECTED[i].pan, DIRECTED[i].tilt,
                        DIRECTED[i].zero_trans && at_reset);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_angles(16'($urandom), 16'($urandom), 1'b0);
    endtask

    function automatic logic [63:0] rand_word;
        return {$urandom, $urandom};
    endfunction

    // receiver stall pattern: switches among always ready, coin toss and mostly stalled
    always @(posedge clk)
    begin
        if (cycle_count % 97 == 0)
            stall_kind <= $urandom_range(0, 2);
        case (stall_kind)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // check each result against the oldest prediction
    always @(posedge clk)
    begin
        pose_out_t exp_pose;
        bit        zt;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("%0t: unexpected transaction, data %h", $realtime, m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_pose = pending_poses.pop_front();
                zt = zero_trans_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[16*i +: 16] !== exp_pose.rot[i])
                    begin
                        $display("%0t: rot_%0d%0d expected %0d actual %0d", $realtime,
                                 i / 3, i % 3, $signed(exp_pose.rot[i]),
                                 $signed(m_axis_tdata[16*i +: 16]));
                        error_count++;
                    end
                for (int i = 0; i < 3; i++)
                begin
                    if (m_axis_tdata[144 + 20*i +: 20] !== exp_pose.trans[i])
                    begin
                        $display("%0t: trans_%0d expected %0d actual %0d", $realtime, i,
                                 $signed(exp_pose.trans[i]),
                                 $signed(m_axis_tdata[144 + 20*i +: 20]));
                        error_count++;
                    end
                    // all lengths still at reset, so the translation is zero outright
                    if (zt && m_axis_tdata[144 + 20*i +: 20] !== 20'd0)
                    begin
                        $display("%0t: trans_%0d expected 0 actual %0d", $realtime, i,
                                 $signed(m_axis_tdata[144 + 20*i +: 20]));
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_pan_tilt_forward_kinematics_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        chain_mode    = 1'b0;
        for (int i = 0; i < 5; i++)
            calib_words[i] = '0;
        error_count   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        stall_kind    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: zero pose, zero lengths, zero twists
        run_directed(1'b1);

        // short chain with arbitrary calibration, upper bits of the mode word set
        load_calibration(64'hffff_ffff_ffff_fff1, rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word());
        run_directed(1'b0);

        // extremes of every calibration field, first in the full chain, then in the short chain
        load_calibration(64'h0, 64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff,
                         64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff,
                         64'hffff_ffff_7fff_7fff);
        run_random(20);
        load_calibration(64'h1, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                         64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                         64'h0000_0000_8000_8000);
        run_random(20);

        // writes to indexes beyond the list must leave calibration alone
        drain_pipeline();
        write_reg(3'd6, rand_word());
        write_reg(3'd7, rand_word());
        run_directed(1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            load_calibration(64'(phase % 2), rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word());
            run_random(RAND_ITEMS / 8);
        end

        drain_pipeline();
        if (error_count == 0)
            $display("tb_pan_tilt_forward_kinematics_unit: done, clean");
        else
            $display("tb_pan_tilt_forward_kinematics_unit: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ptfk_pkg.sv
src/ptfk_sincos.sv
src/ptfk_frames.sv
src/ptfk_compose.sv
src/ptfk_output.sv
src/pan_tilt_forward_kinematics_unit.sv
tb/tb_pan_tilt_forward_kinematics_unit.sv
